### hdl/lrs16k_pkg.sv
// Package for the linear resampler to 16 kHz: constants, command and status types.
// Used by lrs16k_ctrl, lrs16k_dp and the top level. No dependencies.
`default_nettype none

package lrs16k_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RATE_W          = 18;
	localparam int PHASE_W         = 18;
	// phase while it is used as an interpolation weight stays below 16000
	localparam int PHM_W           = 14;

	localparam logic [RATE_W-1:0] OUT_RATE       = 18'd16000;
	localparam logic [RATE_W-1:0] MIN_RATE       = 18'd8000;
	localparam logic [RATE_W-1:0] MAX_RATE       = 18'd192000;
	localparam logic [RATE_W-1:0] LOW_RATE_LIMIT = 18'd1000;

	// 16000 = 2^7 * 125: arithmetic shift first, then divide by 125
	localparam int PRE_SHIFT = 7;
	localparam int DIV_BASE  = 125;
	localparam int REM_W     = 7;

	// divide-by-125 unit works on 24-bit digits of the dividend, MSB first
	localparam int CHUNK_W   = 24;
	localparam int CHUNK_RED = 91;      // 2^24 mod 125
	localparam int CHUNK_QUO = 134217;  // 2^24 div 125
	localparam int VW        = 25;      // partial dividend: 91*rem + digit
	localparam int RECIP_W   = 26;
	localparam logic [RECIP_W-1:0] RECIP = 26'd34359739;  // ceil(2^32 / 125)
	localparam int RECIP_SHIFT = 32;
	localparam int PROD_W    = VW + RECIP_W;
	localparam int QD_W      = PROD_W - RECIP_SHIFT;

	typedef struct packed {
		logic take_first;  // store first sample, no output
		logic take_cur;    // latch current sample, start interpolation
		logic skip_item;   // no output for this item, phase drops by 16000
		logic mul;         // diff * phase
		logic ofs;         // shift and bias, load divider
		logic div_a;       // divider: partial dividend and reciprocal product
		logic div_b;       // divider: quotient digit and remainder
		logic emit;        // load output register
		logic last;        // emitted word ends the item
	} lrs16k_cmd_t;

	typedef struct packed {
		logic have_prev;
		logic phase_wrap;  // phase >= 16000
		logic step_lt;     // phase + rate < 16000
		logic slot_free;   // output register can take a word
	} lrs16k_sts_t;

endpackage

`default_nettype wire

### hdl/lrs16k_ctrl.sv
// Controller state machine of the linear resampler: sequences multiply, bias,
// digit divider and output load. Depends on lrs16k_pkg.
`default_nettype none

module lrs16k_ctrl #(
	parameter int SAMPLE_BITS = lrs16k_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire lrs16k_pkg::lrs16k_sts_t   sts,
	output lrs16k_pkg::lrs16k_cmd_t        cmd
);
	import lrs16k_pkg::*;

	localparam int UW    = SAMPLE_BITS + 8;
	localparam int ND    = (UW + CHUNK_W - 1) / CHUNK_W;
	localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_OFS,
		S_DIVA,
		S_DIVB,
		S_EMIT
	} state_t;

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               second_q, second_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		cnt_d    = cnt_q;
		second_d = second_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!sts.have_prev) begin
						cmd.take_first = 1'b1;
					end else if (sts.phase_wrap) begin
						cmd.skip_item = 1'b1;
					end else begin
						cmd.take_cur = 1'b1;
						second_d     = 1'b0;
						state_d      = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_OFS;
			end
			S_OFS: begin
				cmd.ofs = 1'b1;
				cnt_d   = '0;
				state_d = S_DIVA;
			end
			S_DIVA: begin
				cmd.div_a = 1'b1;
				state_d   = S_DIVB;
			end
			S_DIVB: begin
				cmd.div_b = 1'b1;
				if (cnt_q == CNT_W'(ND - 1)) begin
					state_d = S_EMIT;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_DIVA;
				end
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					cmd.last = second_q || !sts.step_lt;
					if (cmd.last) begin
						state_d = S_IDLE;
					end else begin
						second_d = 1'b1;
						state_d  = S_MUL;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			second_q <= second_d;
		end
	end

endmodule

`default_nettype wire

### hdl/lrs16k_dp.sv
// Datapath of the linear resampler: sample and phase state, rate register,
// interpolation multiply, digit-serial divide by 125, output register. Uses lrs16k_pkg.
`default_nettype none

module lrs16k_dp #(
	parameter int SAMPLE_BITS = lrs16k_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire lrs16k_pkg::lrs16k_cmd_t            cmd,
	output lrs16k_pkg::lrs16k_sts_t                 sts,
	input  wire logic signed [SAMPLE_BITS-1:0]      in_sample,
	input  wire logic                               cfg_we,
	input  wire logic [lrs16k_pkg::RATE_W-1:0]      cfg_wdata,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [SAMPLE_BITS-1:0]           out_sample,
	output logic                                    last_of_run
);
	import lrs16k_pkg::*;

	localparam int NUM_W = SAMPLE_BITS + 15;
	localparam int UW    = SAMPLE_BITS + 8;
	localparam int ND    = (UW + CHUNK_W - 1) / CHUNK_W;
	localparam int UPW   = ND * CHUNK_W;
	localparam int QW    = SAMPLE_BITS + 1;
	// bias that makes the shifted product non-negative; equals 125 * 2^SAMPLE_BITS
	localparam logic [UW-1:0] U_OFS = UW'(DIV_BASE) << SAMPLE_BITS;
	localparam logic [SAMPLE_BITS+1:0] Y_OFS = {2'b01, {SAMPLE_BITS{1'b0}}};

	logic                          have_prev_q;
	logic [PHASE_W-1:0]            phase_q;
	logic [RATE_W-1:0]             eff_rate_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] prev_q, cur_q, out_sample_q;
	logic                          last_q;
	logic signed [NUM_W-1:0]       num_q;
	logic [UPW-1:0]                upad_q, q_q;
	logic [REM_W-1:0]              r_q;
	logic [VW-1:0]                 v_q;
	logic [PROD_W-1:0]             prod_q;

	logic [RATE_W-1:0]             eff_new;
	logic [PHASE_W:0]              phase_sum;
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [PHM_W:0]         ph_m;
	logic signed [SAMPLE_BITS+15:0] mul_full;
	logic signed [NUM_W-1:0]       num_sh, u_sum;
	logic [UW-1:0]                 u;
	logic [CHUNK_W-1:0]            chunk, digit;
	logic [VW-1:0]                 v_next, qd_x, rem;
	logic [QD_W-1:0]               qd;
	logic signed [SAMPLE_BITS+1:0] y_full;

	always_comb begin
		if (cfg_wdata <= LOW_RATE_LIMIT) begin
			eff_new = OUT_RATE;
		end else if (cfg_wdata < MIN_RATE) begin
			eff_new = MIN_RATE;
		end else if (cfg_wdata > MAX_RATE) begin
			eff_new = MAX_RATE;
		end else begin
			eff_new = cfg_wdata;
		end
	end

	assign phase_sum = {1'b0, phase_q} + {1'b0, eff_rate_q};

	// interpolation product: (cur - prev) * phase, phase < 16000 here
	assign diff     = $signed({cur_q[SAMPLE_BITS-1], cur_q}) -
	                  $signed({prev_q[SAMPLE_BITS-1], prev_q});
	assign ph_m     = $signed({1'b0, phase_q[PHM_W-1:0]});
	assign mul_full = diff * ph_m;

	// floor(num / 16000) = floor((floor(num / 128) + bias) / 125) - 2^SAMPLE_BITS
	assign num_sh = num_q >>> PRE_SHIFT;
	assign u_sum  = num_sh + $signed({{(NUM_W-UW){1'b0}}, U_OFS});
	assign u      = u_sum[UW-1:0];

	// one 24-bit digit per pass; remainder below 125 carries into the next digit
	assign chunk  = upad_q[UPW-1 -: CHUNK_W];
	assign v_next = VW'(r_q) * VW'(CHUNK_RED) + VW'(chunk);
	assign qd     = prod_q[PROD_W-1:RECIP_SHIFT];
	assign qd_x   = VW'(qd) * VW'(DIV_BASE);
	assign rem    = v_q - qd_x;
	assign digit  = CHUNK_W'(r_q) * CHUNK_W'(CHUNK_QUO) + CHUNK_W'(qd);

	assign y_full = $signed({{2{prev_q[SAMPLE_BITS-1]}}, prev_q}) +
	                $signed({1'b0, q_q[QW-1:0]}) - $signed(Y_OFS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			phase_q     <= '0;
			eff_rate_q  <= OUT_RATE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_first) begin
				have_prev_q <= 1'b1;
			end
			if (cmd.skip_item) begin
				phase_q <= phase_q - OUT_RATE;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cmd.last) begin
					phase_q <= phase_sum[PHASE_W-1:0] - OUT_RATE;
				end else begin
					phase_q <= phase_sum[PHASE_W-1:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// rate change restarts the stream
			if (cfg_we && (eff_new != eff_rate_q)) begin
				eff_rate_q  <= eff_new;
				have_prev_q <= 1'b0;
				phase_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_first || cmd.skip_item) begin
			prev_q <= in_sample;
		end else if (cmd.emit && cmd.last) begin
			prev_q <= cur_q;
		end
		if (cmd.take_cur) begin
			cur_q <= in_sample;
		end
		if (cmd.mul) begin
			num_q <= mul_full[NUM_W-1:0];
		end
		if (cmd.ofs) begin
			upad_q <= UPW'(u);
			q_q    <= '0;
			r_q    <= '0;
		end else if (cmd.div_b) begin
			upad_q <= upad_q << CHUNK_W;
			q_q    <= (q_q << CHUNK_W) | UPW'(digit);
			r_q    <= rem[REM_W-1:0];
		end
		if (cmd.div_a) begin
			v_q    <= v_next;
			prod_q <= PROD_W'(v_next) * PROD_W'(RECIP);
		end
		if (cmd.emit) begin
			out_sample_q <= y_full[SAMPLE_BITS-1:0];
			last_q       <= cmd.last;
		end
	end

	assign sts.have_prev  = have_prev_q;
	assign sts.phase_wrap = (phase_q >= OUT_RATE);
	assign sts.step_lt    = (phase_sum < {1'b0, OUT_RATE});
	assign sts.slot_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < MAX_RATE)
		else $error("phase out of range");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_rate_q >= MIN_RATE) && (eff_rate_q <= MAX_RATE))
		else $error("effective rate out of range");

	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (phase_q < OUT_RATE))
		else $error("word emitted with phase past interval");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_b |-> (r_q < REM_W'(DIV_BASE)))
		else $error("divider remainder not below 125");

	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_cur |-> (have_prev_q && (phase_q < OUT_RATE)))
		else $error("interpolation started without valid state");
`endif

endmodule

`default_nettype wire

### hdl/linear_resampler_to_16k_top.sv
// Each output word runs through S_MUL, S_OFS, the digit divider (S_DIVA, S_DIVB) and
// S_EMIT, with ND = ceil((SAMPLE_BITS + 8) / 24) passes of the digit divider.
// A sample that yields words holds in_ready low from acceptance until its last word
// is loaded into the output register, including any wait on out_ready; one that
// yields none keeps in_ready high. The shared divide-by-125 unit serves the words in
// turn, so no new sample is taken while one is in progress. Asynchronous reset
// restores 16000 Hz, clears phase and sample history and empties the output register.
`default_nettype none

module linear_resampler_to_16k_top #(
	parameter int SAMPLE_BITS = lrs16k_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               last_of_run,
	input  wire logic                          cfg_we,
	input  wire logic [lrs16k_pkg::RATE_W-1:0] cfg_wdata
);
	import lrs16k_pkg::*;

	lrs16k_cmd_t cmd;
	lrs16k_sts_t sts;

	lrs16k_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lrs16k_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_sample   (in_sample),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
